>>> rtl/rsl_pkg.sv
// Shared types, constants and a helper function of the RMS sound level meter.
package rsl_pkg;

  localparam int DC_FRAC   = 16;  // fraction bits of the DC offset
  localparam int DEV_SHIFT = 12;  // Q12.16 deviation down to Q13.4
  localparam int DIGIT_W   = 4;   // quotient bits per divider step
  localparam int DIVISOR   = 20;  // filter weights are 19/20 and 1/20
  localparam int REM_W     = 5;

  localparam int SUM_W = 38;
  localparam logic [SUM_W-1:0] SUM_MAX = '1;

  localparam int MANT_W = 31;  // Q30 mantissa
  localparam int PROD_W = 2 * MANT_W;
  localparam int FRAC_W = 16;
  localparam int EXP_W  = 6;
  localparam int LOG_W  = EXP_W + FRAC_W;

  localparam int SCALE_W = 22;
  localparam logic [SCALE_W-1:0] DB_PER_LOG2_Q16 = 22'd3156528;
  localparam longint DB_OFFSET_Q16 = 54633450;
  localparam longint ROUND_HALF    = 32768;
  localparam int TP_W   = LOG_W + SCALE_W;
  localparam int TERM_W = TP_W - 16;
  localparam int LVL_W  = TERM_W + 2;

  localparam int LEVEL_W = 11;
  localparam logic [LEVEL_W-1:0] LEVEL_FLOOR = 11'd480;
  localparam logic [LEVEL_W-1:0] LEVEL_CEIL  = 11'd2000;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV,
    S_DEV,
    S_SQ,
    S_ACC,
    S_CHK,
    S_NORM,
    S_MUL,
    S_SEL,
    S_TERM,
    S_LVL,
    S_ZERO
  } state_t;

  typedef struct packed {
    logic load;
    logic div_step;
    logic dev;
    logic square;
    logic accum;
    logic snap;
    logic norm_shift;
    logic mant_load;
    logic mul;
    logic sel;
    logic term;
    logic push_level;
    logic push_floor;
  } ctl_t;

  typedef struct packed {
    logic sum_zero;
    logic norm_done;
  } sts_t;

  // Elaboration-time dB term of a constant: (log2_q16(v) * scale) >> 16.
  function automatic longint unsigned log_term_const(longint unsigned v);
    longint unsigned t;
    longint unsigned m;
    longint unsigned frac;
    longint unsigned e;
    t    = v;
    e    = 0;
    frac = 0;
    for (int i = 0; i < 64; i++) begin
      if (t > 1) begin
        t = t >> 1;
        e = e + 1;
      end
    end
    if (e >= 30) m = v >> (e - 30);
    else         m = v << (30 - e);
    for (int i = 0; i < FRAC_W; i++) begin
      m    = (m * m) >> 30;
      frac = frac << 1;
      if (m >= (64'd1 << 31)) begin
        m    = m >> 1;
        frac = frac | 64'd1;
      end
    end
    return (((e << 16) | frac) * longint'(DB_PER_LOG2_Q16)) >> 16;
  endfunction

endpackage

>>> rtl/rsl_sample_if.sv
// Sample request channel: valid/ready handshake carrying one converter reading.
interface rsl_sample_if #(parameter int SAMPLE_BITS = 12);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

>>> rtl/rsl_level_if.sv
// Level request channel: valid/ready handshake carrying one window result.
interface rsl_level_if;
  import rsl_pkg::*;

  logic               valid;
  logic               ready;
  logic [LEVEL_W-1:0] level_db;
  logic               floor_clamped;

  modport source (output valid, output level_db, output floor_clamped, input ready);
  modport sink (input valid, input level_db, input floor_clamped, output ready);
endinterface

>>> rtl/rsl_ctrl.sv
// Controller: sequences the filter divide, accumulate and log conversion.
module rsl_ctrl #(
  parameter int WINDOW_SAMPLES = 64,
  parameter int DIV_STEPS      = 9
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output rsl_pkg::ctl_t ctl,
  input  rsl_pkg::sts_t sts
);
  import rsl_pkg::*;

  localparam int CNT_W = $clog2(WINDOW_SAMPLES);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WINDOW_SAMPLES - 1);
  localparam int STEP_W = $clog2(DIV_STEPS);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DIV_STEPS - 1);
  localparam int ITER_W = $clog2(FRAC_W);
  localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(FRAC_W - 1);

  state_t            state, state_next;
  logic [CNT_W-1:0]  count, count_next;
  logic [STEP_W-1:0] step, step_next;
  logic [ITER_W-1:0] iter, iter_next;
  logic              out_free;

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      step  <= '0;
      iter  <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
      step  <= step_next;
      iter  <= iter_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.push_level || ctl.push_floor) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_comb begin
    state_next = state;
    count_next = count;
    step_next  = step;
    iter_next  = iter;
    in_ready   = 1'b0;
    ctl        = '0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.load   = 1'b1;
          step_next  = '0;
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        ctl.div_step = 1'b1;
        if (step == STEP_LAST) state_next = S_DEV;
        else                   step_next  = step + 1'b1;
      end
      S_DEV: begin
        ctl.dev    = 1'b1;
        state_next = S_SQ;
      end
      S_SQ: begin
        ctl.square = 1'b1;
        state_next = S_ACC;
      end
      S_ACC: begin
        ctl.accum = 1'b1;
        if (count == CNT_LAST) begin
          count_next = '0;
          state_next = S_CHK;
        end else begin
          count_next = count + 1'b1;
          state_next = S_IDLE;
        end
      end
      S_CHK: begin
        ctl.snap = 1'b1;
        if (sts.sum_zero) state_next = S_ZERO;
        else              state_next = S_NORM;
      end
      S_NORM: begin
        if (sts.norm_done) begin
          ctl.mant_load = 1'b1;
          iter_next     = '0;
          state_next    = S_MUL;
        end else begin
          ctl.norm_shift = 1'b1;
        end
      end
      S_MUL: begin
        ctl.mul    = 1'b1;
        state_next = S_SEL;
      end
      S_SEL: begin
        ctl.sel = 1'b1;
        if (iter == ITER_LAST) begin
          state_next = S_TERM;
        end else begin
          iter_next  = iter + 1'b1;
          state_next = S_MUL;
        end
      end
      S_TERM: begin
        ctl.term   = 1'b1;
        state_next = S_LVL;
      end
      S_LVL: begin
        if (out_free) begin
          ctl.push_level = 1'b1;
          state_next     = S_IDLE;
        end
      end
      S_ZERO: begin
        if (out_free) begin
          ctl.push_floor = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/rsl_datapath.sv
// Datapath: DC filter with digit-serial divide by 20, energy sum, log2 and dB scaling.
module rsl_datapath #(
  parameter int SAMPLE_BITS    = 12,
  parameter int WINDOW_SAMPLES = 64,
  parameter int DIV_STEPS      = 9
) (
  input  logic                            clk,
  input  logic                            rst,
  input  rsl_pkg::ctl_t                   ctl,
  output rsl_pkg::sts_t                   sts,
  input  logic [SAMPLE_BITS-1:0]          sample,
  output logic [rsl_pkg::LEVEL_W-1:0]     level_db,
  output logic                            floor_clamped
);
  import rsl_pkg::*;

  localparam int DC_W   = SAMPLE_BITS + DC_FRAC;
  localparam int SH_W   = DIV_STEPS * DIGIT_W;
  localparam int RCAT_W = REM_W + DIGIT_W;
  localparam int Q_W    = DC_W - DEV_SHIFT + 1;
  localparam int SQ_W   = 2 * Q_W;
  localparam int ADD_W  = ((SQ_W > SUM_W) ? SQ_W : SUM_W) + 1;
  localparam int R_W    = LVL_W - 16;
  localparam longint LVL_BIAS = DB_OFFSET_Q16 + ROUND_HALF
                              - longint'(log_term_const(256 * WINDOW_SAMPLES));
  localparam logic signed [LVL_W-1:0] LVL_BIAS_V = LVL_W'(LVL_BIAS);

  logic [SAMPLE_BITS-1:0] x;
  logic [DC_W-1:0]        dc;
  logic [SH_W-1:0]        nsh;
  logic [REM_W-1:0]       rem;
  logic [SH_W-1:0]        quo;
  logic [Q_W-1:0]         q;
  logic [SQ_W-1:0]        sq;
  logic [SUM_W-1:0]       sum;
  logic [SUM_W-1:0]       v;
  logic [EXP_W-1:0]       e;
  logic [MANT_W-1:0]      m;
  logic [PROD_W-1:0]      p;
  logic [FRAC_W-1:0]      frac;
  logic [TP_W-1:0]        tprod;

  logic [SH_W-1:0]         numer;
  logic [RCAT_W-1:0]       rcat;
  logic [DIGIT_W-1:0]      qd;
  logic [REM_W-1:0]        rrem;
  logic [DC_W-1:0]         newdc;
  logic signed [DC_W:0]    diff;
  logic signed [DC_W:0]    dsh;
  logic [DC_W:0]           dmag;
  logic [ADD_W-1:0]        tot;
  logic [SUM_W-1:0]        sum_acc;
  logic [MANT_W-1:0]       mant_sel;
  logic [TERM_W-1:0]       term;
  logic signed [LVL_W-1:0] lvl;
  logic [R_W-1:0]          r;
  logic [LEVEL_W-1:0]      lvl_out;
  logic                    lvl_flag;

  // 19*dc + (x << 16) as shifts and adds
  assign numer = (SH_W'(dc) << 4) + (SH_W'(dc) << 1) + SH_W'(dc)
               + (SH_W'(sample) << DC_FRAC);

  // long division by 20, one quotient nibble per step; remainder stays below 20
  assign rcat = {rem, nsh[SH_W-1 -: DIGIT_W]};
  always_comb begin
    qd = '0;
    for (int k = 1; k < (1 << DIGIT_W); k++) begin
      if (rcat >= RCAT_W'(k * DIVISOR)) qd = DIGIT_W'(k);
    end
  end
  assign rrem = REM_W'(rcat - RCAT_W'(qd) * RCAT_W'(DIVISOR));

  // floor of the deviation at Q13.4 is an arithmetic shift; keep its magnitude
  assign newdc = quo[DC_W-1:0];
  assign diff  = $signed({1'b0, x, {DC_FRAC{1'b0}}}) - $signed({1'b0, newdc});
  assign dsh   = diff >>> DEV_SHIFT;
  assign dmag  = dsh[DC_W] ? DC_W'(0) - dsh : dsh;

  assign tot     = ADD_W'(sum) + ADD_W'(sq);
  assign sum_acc = (tot > ADD_W'(SUM_MAX)) ? SUM_MAX : tot[SUM_W-1:0];

  // m*m >> 30, halved when it reaches 2.0
  assign mant_sel = p[PROD_W-1] ? p[PROD_W-1 -: MANT_W] : p[PROD_W-2 -: MANT_W];

  assign term = tprod[TP_W-1:16];
  assign lvl  = $signed({2'b00, term}) + LVL_BIAS_V;
  assign r    = lvl[LVL_W-1:16];

  always_comb begin
    lvl_out  = LEVEL_FLOOR;
    lvl_flag = 1'b1;
    if (!lvl[LVL_W-1] && r >= R_W'(LEVEL_FLOOR)) begin
      lvl_flag = 1'b0;
      lvl_out  = (r > R_W'(LEVEL_CEIL)) ? LEVEL_CEIL : r[LEVEL_W-1:0];
    end
  end

  assign sts.sum_zero  = (sum == '0);
  assign sts.norm_done = v[SUM_W-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      dc  <= '0;
      sum <= '0;
    end else begin
      if (ctl.dev) dc <= newdc;
      if (ctl.accum) begin
        sum <= sum_acc;
      end else if (ctl.snap) begin
        sum <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      x   <= sample;
      nsh <= numer;
      rem <= '0;
      quo <= '0;
    end else if (ctl.div_step) begin
      nsh <= nsh << DIGIT_W;
      rem <= rrem;
      quo <= {quo[SH_W-DIGIT_W-1:0], qd};
    end
    if (ctl.dev) q <= dmag[Q_W-1:0];
    if (ctl.square) sq <= SQ_W'(q) * SQ_W'(q);
    if (ctl.snap) begin
      v <= sum;
      e <= EXP_W'(SUM_W - 1);
    end else if (ctl.norm_shift) begin
      v <= v << 1;
      e <= e - 1'b1;
    end
    if (ctl.mant_load) begin
      m    <= v[SUM_W-1 -: MANT_W];
      frac <= '0;
    end else if (ctl.sel) begin
      m    <= mant_sel;
      frac <= {frac[FRAC_W-2:0], p[PROD_W-1]};
    end
    if (ctl.mul) p <= PROD_W'(m) * PROD_W'(m);
    if (ctl.term) tprod <= TP_W'({e, frac}) * TP_W'(DB_PER_LOG2_Q16);
    if (ctl.push_level) begin
      level_db      <= lvl_out;
      floor_clamped <= lvl_flag;
    end else if (ctl.push_floor) begin
      level_db      <= LEVEL_FLOOR;
      floor_clamped <= 1'b1;
    end
  end

endmodule

>>> rtl/rms_sound_level_meter.sv
// Each sample occupies the block through an accept state, the offset filter's divide by 20
// at four quotient bits a cycle (DIV_STEPS = ceil((SAMPLE_BITS + 21) / 4) steps), then
// deviation, square and accumulate. The sample that closes a window of WINDOW_SAMPLES adds
// the log conversion before the next request is taken: a check of the energy sum, shifts
// that normalise it to its top bit, mantissa squaring on one 31x31 multiplier, then the
// dB term and the level; a window of zero energy goes from the check to the floor level.
// The result sits in an output register, so the next sample is taken while it waits.
// Level is in 1/16 dB SPL, from 480 to 2000.
module rms_sound_level_meter #(
  parameter int WINDOW_SAMPLES = 64,
  parameter int SAMPLE_BITS    = 12
) (
  input  logic         clk,
  input  logic         rst,
  rsl_sample_if.sink   samples,
  rsl_level_if.source  levels
);
  import rsl_pkg::*;

  localparam int DIV_STEPS = (SAMPLE_BITS + DC_FRAC + REM_W + DIGIT_W - 1) / DIGIT_W;

  ctl_t ctl;
  sts_t sts;

  rsl_ctrl #(
    .WINDOW_SAMPLES (WINDOW_SAMPLES),
    .DIV_STEPS      (DIV_STEPS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (samples.valid),
    .in_ready  (samples.ready),
    .out_valid (levels.valid),
    .out_ready (levels.ready),
    .ctl       (ctl),
    .sts       (sts)
  );

  rsl_datapath #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .WINDOW_SAMPLES (WINDOW_SAMPLES),
    .DIV_STEPS      (DIV_STEPS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .ctl           (ctl),
    .sts           (sts),
    .sample        (samples.sample),
    .level_db      (levels.level_db),
    .floor_clamped (levels.floor_clamped)
  );

endmodule

>>> rtl/rsl_checker.sv
// Port checker for the sound level meter, bound to the top level.
module rsl_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [rsl_pkg::LEVEL_W-1:0] level_db,
  input logic                        floor_clamped
);
  import rsl_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result request dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(level_db) && $stable(floor_clamped))
    else $error("result payload changed while stalled");

  a_level_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> level_db >= LEVEL_FLOOR && level_db <= LEVEL_CEIL)
    else $error("level outside 30 dB to 125 dB");

  a_floor_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid && floor_clamped |-> level_db == LEVEL_FLOOR)
    else $error("floor flag set on a level above the floor");

  // a sample keeps the filter divider busy, so no request is taken back to back
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("sample request taken while the previous one is in work");

endmodule

bind rms_sound_level_meter rsl_checker u_rsl_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (samples.valid),
  .in_ready      (samples.ready),
  .out_valid     (levels.valid),
  .out_ready     (levels.ready),
  .level_db      (levels.level_db),
  .floor_clamped (levels.floor_clamped)
);

>>> tb/sv/rms_sound_level_meter_tb.sv
// Self-checking testbench for the RMS sound level meter: windowed samples in, levels checked.
module rms_sound_level_meter_tb;
  import rsl_pkg::*;

  localparam int WINDOW         = 64;
  localparam int SMP_W          = 12;
  localparam int RANDOM_WINDOWS = 16;
  localparam int CALM_WINDOWS   = 4;
  localparam int CYCLE_LIMIT    = 500000;

  typedef enum logic [1:0] {PAT_CONST, PAT_ALT, PAT_PULSE, PAT_RAMP} pattern_t;
  typedef enum logic [1:0] {MODE_WIDE, MODE_NOISE, MODE_HOLD, MODE_RAIL} noise_mode_t;

  // One directed window: pattern, two operands, optional typed-in result.
  typedef struct packed {
    pattern_t           pat;
    logic [SMP_W-1:0]   a;
    logic [SMP_W-1:0]   b;
    logic               typed;
    logic [LEVEL_W-1:0] lvl;
    logic               flag;
  } window_row_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] lvl;
    logic               flag;
  } level_rec_t;

  localparam window_row_t PLAN [10] = '{
    '{PAT_CONST, 12'd0,    12'd0,    1'b1, 11'd480, 1'b1},  // silence straight after reset
    '{PAT_PULSE, 12'd1,    12'd0,    1'b0, 11'd0,   1'b0},  // faint tick, near the floor
    '{PAT_PULSE, 12'd4095, 12'd0,    1'b0, 11'd0,   1'b0},  // one loud click
    '{PAT_CONST, 12'd4095, 12'd0,    1'b0, 11'd0,   1'b0},  // full-scale step, offset catching up
    '{PAT_ALT,   12'd0,    12'd4095, 1'b0, 11'd0,   1'b0},  // loudest square wave
    '{PAT_ALT,   12'd4095, 12'd0,    1'b0, 11'd0,   1'b0},
    '{PAT_ALT,   12'd2047, 12'd2048, 1'b0, 11'd0,   1'b0},  // one LSB around mid-scale
    '{PAT_ALT,   12'hAAA,  12'h555,  1'b0, 11'd0,   1'b0},
    '{PAT_RAMP,  12'd0,    12'd64,   1'b0, 11'd0,   1'b0},
    '{PAT_RAMP,  12'd4095, 12'd4095, 1'b0, 11'd0,   1'b0}   // falling ramp by wrap-around
  };

  logic clk = 1'b0;
  logic rst;

  rsl_sample_if #(.SAMPLE_BITS(SMP_W)) sample_ch ();
  rsl_level_if                         level_ch ();

  rms_sound_level_meter #(
    .WINDOW_SAMPLES(WINDOW),
    .SAMPLE_BITS   (SMP_W)
  ) dut (
    .clk    (clk),
    .rst    (rst),
    .samples(sample_ch.sink),
    .levels (level_ch.source)
  );

  always #5 clk = ~clk;

  // predictor state
  logic [27:0]    dc_track;
  logic [SUM_W-1:0] energy_acc;
  int unsigned    window_fill;

  level_rec_t level_q[$];
  level_rec_t want;
  int errors    = 0;
  int busy_pct  = 0;
  int windows_seen = 0;
  int cycles;

  // log2 in Q16: top set bit, then 16 fraction bits by squaring a Q30 mantissa
  function automatic logic [21:0] log2_fix(logic [SUM_W-1:0] v);
    int unsigned top;
    logic [63:0] m;
    logic [15:0] frac;
    top  = 0;
    frac = '0;
    for (int i = 0; i < SUM_W; i++)
      if (v[i]) top = i;
    if (top >= 30) m = 64'(v) >> (top - 30);
    else           m = 64'(v) << (30 - top);
    for (int i = 0; i < 16; i++) begin
      m    = (m * m) >> 30;
      frac = {frac[14:0], 1'b0};
      if (m >= (64'd1 << 31)) begin
        m       = m >> 1;
        frac[0] = 1'b1;
      end
    end
    return {top[5:0], frac};
  endfunction

  function automatic logic [63:0] db_term(logic [21:0] lg);
    return (64'(lg) * 64'(DB_PER_LOG2_Q16)) >> 16;
  endfunction

  // Advances the offset tracker and energy sum; returns 1 when a window closes.
  function automatic bit take_sample(logic [SMP_W-1:0] s, output logic [LEVEL_W-1:0] lvl,
                                     output logic flag);
    logic [63:0] xs;
    logic [63:0] nxt;
    logic [63:0] q;
    logic [63:0] sq;
    logic [63:0] pos;
    logic [63:0] neg;
    logic [63:0] r;
    xs       = 64'(s) << 16;
    nxt      = (64'd19 * 64'(dc_track) + xs) / 64'd20;
    dc_track = nxt[27:0];
    if (xs >= nxt) q = (xs - nxt) >> 12;
    else           q = (nxt - xs + 64'd4095) >> 12;  // floored deviation, as magnitude
    sq = q * q;
    if (sq > 64'(SUM_MAX) - 64'(energy_acc)) energy_acc = SUM_MAX;
    else                                     energy_acc = energy_acc + sq[SUM_W-1:0];
    window_fill++;
    lvl  = LEVEL_FLOOR;
    flag = 1'b1;
    if (window_fill < WINDOW) return 1'b0;
    if (energy_acc != '0) begin
      pos = db_term(log2_fix(energy_acc)) + 64'(DB_OFFSET_Q16);
      neg = db_term(log2_fix(SUM_W'(256 * WINDOW)));
      if (pos > neg) begin
        r = (pos - neg + 64'(ROUND_HALF)) >> 16;
        if (r >= 64'(LEVEL_FLOOR)) begin
          flag = 1'b0;
          lvl  = (r > 64'(LEVEL_CEIL)) ? LEVEL_CEIL : r[LEVEL_W-1:0];
        end
      end
    end
    energy_acc  = '0;
    window_fill = 0;
    return 1'b1;
  endfunction

  task automatic report_mismatch(string what);
    $display("[%0t] level check failed: %s", $time, what);
    errors++;
  endtask

  // Called at a falling edge; returns at the falling edge after the request is taken.
  task automatic feed(logic [SMP_W-1:0] s, bit typed, logic [LEVEL_W-1:0] t_lvl,
                      logic t_flag);
    level_rec_t rec;
    int gap;
    gap = 0;
    if (busy_pct != 0 && $urandom_range(0, 99) < busy_pct) gap = $urandom_range(1, 17);
    if (gap != 0) begin
      sample_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    sample_ch.valid  <= 1'b1;
    sample_ch.sample <= s;
    @(posedge clk);
    while (!sample_ch.ready) @(posedge clk);
    if (take_sample(s, rec.lvl, rec.flag)) begin
      if (typed) begin
        rec.lvl  = t_lvl;
        rec.flag = t_flag;
      end
      level_q.push_back(rec);
    end
    @(negedge clk);
  endtask

  // result side: stalls in bursts, mostly while a level is on offer
  initial begin
    level_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (busy_pct != 0 &&
          $urandom_range(0, 99) < (level_ch.valid ? 60 : busy_pct / 4)) begin
        level_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(negedge clk);
      end
      level_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && level_ch.valid && level_ch.ready) begin
      if (level_q.size() == 0) begin
        report_mismatch($sformatf("unexpected level %0d clamp %0b",
                                  level_ch.level_db, level_ch.floor_clamped));
      end else begin
        want = level_q.pop_front();
        if (level_ch.level_db !== want.lvl)
          report_mismatch($sformatf("window %0d level_db %0d, want %0d",
                                    windows_seen, level_ch.level_db, want.lvl));
        if (level_ch.floor_clamped !== want.flag)
          report_mismatch($sformatf("window %0d floor_clamped %0b, want %0b",
                                    windows_seen, level_ch.floor_clamped, want.flag));
      end
      windows_seen++;
    end
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("rms_sound_level_meter: mismatch");
    $finish;
  end

  initial begin
    logic [SMP_W-1:0] val;
    logic [SMP_W-1:0] last;
    noise_mode_t mode;
    int base;
    int amp;
    int v;
    rst              = 1'b1;
    sample_ch.valid  = 1'b0;
    sample_ch.sample = '0;
    dc_track         = '0;
    energy_acc       = '0;
    window_fill      = 0;
    last             = '0;
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    busy_pct = 20;
    for (int r = 0; r < $size(PLAN); r++) begin
      for (int i = 0; i < WINDOW; i++) begin
        case (PLAN[r].pat)
          PAT_CONST: val = PLAN[r].a;
          PAT_ALT:   val = i[0] ? PLAN[r].b : PLAN[r].a;
          PAT_PULSE: val = (i == 0) ? PLAN[r].a : PLAN[r].b;
          default:   val = SMP_W'(PLAN[r].a + i * PLAN[r].b);
        endcase
        feed(val, PLAN[r].typed && i == WINDOW - 1, PLAN[r].lvl, PLAN[r].flag);
        last = val;
      end
    end

    // hold off until the block has drained every pending level
    sample_ch.valid <= 1'b0;
    while (level_q.size() != 0) @(negedge clk);

    for (int w = 0; w < RANDOM_WINDOWS; w++) begin
      if (w >= RANDOM_WINDOWS - CALM_WINDOWS) begin
        busy_pct = 0;
      end else begin
        case ($urandom_range(0, 2))
          0:       busy_pct = 0;
          1:       busy_pct = 15;
          default: busy_pct = 40;
        endcase
      end
      // a long steady stretch lets the offset settle, down to zero energy
      if (w >= 4 && w < 12) mode = MODE_HOLD;
      else                  mode = noise_mode_t'($urandom_range(0, 3));
      base = $urandom_range(0, 4095);
      amp  = (1 << $urandom_range(0, 11)) - 1;
      for (int i = 0; i < WINDOW; i++) begin
        case (mode)
          MODE_WIDE: val = $urandom_range(0, 4095);
          MODE_NOISE: begin
            v = base + int'($urandom_range(0, 2 * amp)) - amp;
            if (v < 0)    v = 0;
            if (v > 4095) v = 4095;
            val = v[SMP_W-1:0];
          end
          MODE_HOLD: val = last;
          default:   val = $urandom_range(0, 1) ? 12'hFFF : 12'h000;
        endcase
        feed(val, 1'b0, '0, 1'b0);
        last = val;
      end
    end
    sample_ch.valid <= 1'b0;

    while (level_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("rms_sound_level_meter: match");
    end else begin
      $display("rms_sound_level_meter: mismatch");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/rsl_pkg.sv
rtl/rsl_sample_if.sv
rtl/rsl_level_if.sv
rtl/rsl_ctrl.sv
rtl/rsl_datapath.sv
rtl/rms_sound_level_meter.sv
rtl/rsl_checker.sv
tb/sv/rms_sound_level_meter_tb.sv
